### hdl/mwa_pkg.sv
// Shared types and fixed field widths for the max window average block.
package mwa_pkg;

    // Fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 7;
    localparam int SUM_OUT_W = 22;
    localparam int AVG_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 56;

    localparam logic [LEN_W-1:0] WINDOW_LEN_RST = 7'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // capture request, issue ring read
        logic update;     // update sums, write ring
        logic div_start;  // load the divider
        logic load_out;   // load the result register
        logic clear;      // clear per-sequence state
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;
        logic too_short;
        logic div_done;
    } status_t;

endpackage

### hdl/max_window_average_core.sv
// Top level of the max window average block: largest fixed-window sum and its average.
//
//  Channel  Dir  Handshake              Payload
//  s_       in   s_tvalid / s_tready    tdata: sample[15:0]; tlast: last
//  m_       out  m_tvalid / m_tready    tdata: max_sum[21:0], average[53:22]; tuser: too_short
//  cfg_     in   cfg_wr_en              cfg_wr_data: window_len[6:0]
//
// Each sample is accepted in ST_IDLE, which reads the ring store; ST_UPDATE then updates the
// sums and writes the ring. A last sample goes on through ST_DIV_INIT and the serial divider,
// one quotient bit per cycle (SAMPLE_W + 16 + clog2(window max + 1) bits, 39 at the defaults),
// and ST_FINISH loads the result. A too-short sequence skips the divider. aresetn is synchronous,
// active low; the ring store is not cleared. A result waiting on m_tready does not block non-last samples.
module max_window_average_core #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [mwa_pkg::LEN_W-1:0]            cfg_wr_data,   // window_len
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mwa_pkg::TDATA_IN_W-1:0]       s_tdata,       // sample
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mwa_pkg::TDATA_OUT_W-1:0]      m_tdata,       // max_sum, average, pad
    output logic                                 m_tuser        // too_short
);

    mwa_pkg::cmd_t    cmd;
    mwa_pkg::status_t status;

    logic signed [mwa_pkg::SUM_OUT_W-1:0] max_sum;
    logic signed [mwa_pkg::AVG_W-1:0]     average;

    mwa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mwa_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_sample     ($signed(s_tdata[mwa_pkg::SAMPLE_W-1:0])),
        .in_last       (s_tlast),
        .cmd           (cmd),
        .status        (status),
        .out_max_sum   (max_sum),
        .out_average   (average),
        .out_too_short (m_tuser)
    );

    // Pack result fields, lowest first, zero pad to whole bytes
    assign m_tdata = {
        {(mwa_pkg::TDATA_OUT_W - mwa_pkg::SUM_OUT_W - mwa_pkg::AVG_W){1'b0}},
        average,
        max_sum
    };

endmodule

### hdl/mwa_div.sv
// Restoring divider, one quotient bit per cycle, on magnitudes with sign fixup.
module mwa_div #(
    parameter int DIVD_W = 39,
    parameter int DIVS_W = 7
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DIVD_W-1:0]        dividend_mag,
    input  logic                     negative,
    input  logic [DIVS_W-1:0]        divisor,
    output logic                     done,
    output logic signed [DIVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W:0]   rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [DIVS_W:0]   rem_sh;
    logic              fits;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        rem_sh = {rem_reg[DIVS_W-1:0], quo_reg[DIVD_W-1]};
        fits   = (rem_sh >= {1'b0, dvs_reg});
    end

    // Iteration counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(DIVD_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Quotient and remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend_mag;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= negative;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
            rem_reg <= fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
        end
    end

    assign done     = (cnt_reg == '0);
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

### hdl/mwa_ctrl.sv
// Sequencing state machine for the max window average block.
module mwa_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  mwa_pkg::status_t status,
    output mwa_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_UPDATE   = 5'b00010,
        ST_DIV_INIT = 5'b00100,
        ST_DIVIDE   = 5'b01000,
        ST_FINISH   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = status.last ? ST_DIV_INIT : ST_IDLE;
            end
            ST_DIV_INIT: begin
                if (status.too_short) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on load, dropped when taken
    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/mwa_datapath.sv
// Ring store, running and best sums, divider and result register.
module mwa_datapath #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [mwa_pkg::LEN_W-1:0]            cfg_wr_data,
    input  logic signed [mwa_pkg::SAMPLE_W-1:0]  in_sample,
    input  logic                                 in_last,
    input  mwa_pkg::cmd_t                        cmd,
    output mwa_pkg::status_t                     status,
    output logic signed [mwa_pkg::SUM_OUT_W-1:0] out_max_sum,
    output logic signed [mwa_pkg::AVG_W-1:0]     out_average,
    output logic                                 out_too_short
);

    localparam int LEN_MAX = (1 << mwa_pkg::LEN_W) - 1;
    localparam int EFF_MAX = (WINDOW_MAX < LEN_MAX) ? WINDOW_MAX : LEN_MAX;
    localparam int ALEN_W  = $clog2(EFF_MAX + 1);
    localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int IDX_W   = ((PTR_W > ALEN_W) ? PTR_W : ALEN_W) + 1;
    localparam int SUM_W   = mwa_pkg::SAMPLE_W + ALEN_W;
    localparam int DIVD_W  = SUM_W + mwa_pkg::FRAC_W;

    logic [mwa_pkg::LEN_W-1:0]           win_len_reg;
    logic [ALEN_W-1:0]                   active_len_reg;
    logic [ALEN_W-1:0]                   filled_reg;
    logic [PTR_W-1:0]                    wp_reg;
    logic signed [SUM_W-1:0]             sum_reg;
    logic signed [SUM_W-1:0]             best_reg;
    logic signed [mwa_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                last_reg;
    logic signed [mwa_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic signed [mwa_pkg::SAMPLE_W-1:0] ring_mem [WINDOW_MAX];

    logic [ALEN_W-1:0]       eff_len;
    logic [ALEN_W-1:0]       len_now;
    logic [IDX_W-1:0]        wp_ext;
    logic [IDX_W-1:0]        len_ext;
    logic [PTR_W-1:0]        rd_idx;
    logic [PTR_W-1:0]        wp_inc;
    logic                    filling;
    logic [ALEN_W-1:0]       filled_inc;
    logic signed [SUM_W-1:0] sum_add;
    logic signed [SUM_W-1:0] sum_slide;
    logic [SUM_W-1:0]        best_mag;
    logic                    div_done;
    logic signed [DIVD_W-1:0] quotient;
    logic signed [SUM_W+mwa_pkg::SUM_OUT_W-1:0] best_ext;

    // Window length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= mwa_pkg::WINDOW_LEN_RST;
        end else if (cfg_wr_en) begin
            win_len_reg <= cfg_wr_data;
        end
    end

    // Effective length: zero reads as one, saturate at the ring depth
    always_comb begin
        if (win_len_reg == '0) begin
            eff_len = ALEN_W'(1);
        end else if (int'(win_len_reg) > EFF_MAX) begin
            eff_len = ALEN_W'(EFF_MAX);
        end else begin
            eff_len = ALEN_W'(win_len_reg);
        end
        len_now = (filled_reg == '0) ? eff_len : active_len_reg;
    end

    // Slot of the sample that leaves the window
    always_comb begin
        wp_ext  = IDX_W'(wp_reg);
        len_ext = IDX_W'(len_now);
        if (wp_ext >= len_ext) begin
            rd_idx = PTR_W'(wp_ext - len_ext);
        end else begin
            rd_idx = PTR_W'(wp_ext + IDX_W'(WINDOW_MAX) - len_ext);
        end
        wp_inc = (wp_reg == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;
    end

    // Sum arithmetic
    always_comb begin
        filling    = (filled_reg < active_len_reg);
        filled_inc = filled_reg + 1'b1;
        sum_add    = sum_reg + SUM_W'(sample_reg);
        sum_slide  = sum_add - SUM_W'(rd_data_reg);
    end

    // Request capture and ring read
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg  <= in_sample;
            last_reg    <= in_last;
            rd_data_reg <= ring_mem[rd_idx];
        end
        if (cmd.update) begin
            ring_mem[wp_reg] <= sample_reg;
        end
    end

    // Per-sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_len_reg <= ALEN_W'(1);
            filled_reg     <= '0;
            wp_reg         <= '0;
            sum_reg        <= '0;
            best_reg       <= '0;
        end else if (cmd.clear) begin
            filled_reg <= '0;
            wp_reg     <= '0;
            sum_reg    <= '0;
            best_reg   <= '0;
        end else begin
            if (cmd.accept && filled_reg == '0) begin
                active_len_reg <= eff_len;
            end
            if (cmd.update) begin
                wp_reg <= wp_inc;
                if (filling) begin
                    sum_reg    <= sum_add;
                    filled_reg <= filled_inc;
                    if (filled_inc == active_len_reg) begin
                        best_reg <= sum_add;
                    end
                end else begin
                    sum_reg <= sum_slide;
                    if (sum_slide > best_reg) begin
                        best_reg <= sum_slide;
                    end
                end
            end
        end
    end

    // Average: best sum scaled by 2^16 over the window length
    assign best_mag = best_reg[SUM_W-1] ? SUM_W'(-best_reg) : SUM_W'(best_reg);

    mwa_div #(
        .DIVD_W (DIVD_W),
        .DIVS_W (ALEN_W)
    ) u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (cmd.div_start),
        .dividend_mag ({best_mag, {mwa_pkg::FRAC_W{1'b0}}}),
        .negative     (best_reg[SUM_W-1]),
        .divisor      (active_len_reg),
        .done         (div_done),
        .quotient     (quotient)
    );

    // Result register
    assign best_ext = {{mwa_pkg::SUM_OUT_W{best_reg[SUM_W-1]}}, best_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_too_short <= filling;
            if (filling) begin
                out_max_sum <= '0;
                out_average <= '0;
            end else begin
                out_max_sum <= best_ext[mwa_pkg::SUM_OUT_W-1:0];
                out_average <= quotient[mwa_pkg::AVG_W-1:0];
            end
        end
    end

    assign status.last      = last_reg;
    assign status.too_short = filling;
    assign status.div_done  = div_done;

endmodule

### test/mwa_window_checker.sv
`timescale 1ns / 1ps
// Watches the max window average channels, predicts every result and checks it field by field.
module mwa_window_checker #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mwa_pkg::LEN_W-1:0]        cfg_wr_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [mwa_pkg::TDATA_IN_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [mwa_pkg::TDATA_OUT_W-1:0]  m_tdata,
    input  logic                             m_tuser,
    output int                               fail_count,
    output int                               in_flight,
    output int                               results_seen
);

    localparam int SLOT_W = $clog2(WINDOW_MAX);

    typedef struct packed {
        logic signed [mwa_pkg::SUM_OUT_W-1:0] max_sum;
        logic signed [mwa_pkg::AVG_W-1:0]     average;
        logic                                 too_short;
    } window_result_t;

    // Predicted state of the block
    logic signed [mwa_pkg::SAMPLE_W-1:0]  ring [WINDOW_MAX];
    logic [SLOT_W-1:0]                    wr_slot;
    logic [mwa_pkg::LEN_W-1:0]            fill_cnt;
    logic [mwa_pkg::LEN_W-1:0]            active_len;
    logic [mwa_pkg::LEN_W-1:0]            window_reg;
    logic signed [mwa_pkg::SUM_OUT_W-1:0] run_sum;
    logic signed [mwa_pkg::SUM_OUT_W-1:0] best_sum;

    window_result_t expected_results [$];
    int err_cnt  = 0;
    int seen_cnt = 0;

    assign fail_count   = err_cnt;
    assign results_seen = seen_cnt;

    // Zero and oversize lengths are clamped into 1..WINDOW_MAX
    function automatic logic [mwa_pkg::LEN_W-1:0] usable_len(
        input logic [mwa_pkg::LEN_W-1:0] v
    );
        int n;
        n = int'(v);
        if (n == 0)
            n = 1;
        if (n > WINDOW_MAX)
            n = WINDOW_MAX;
        return n[mwa_pkg::LEN_W-1:0];
    endfunction

    task automatic clear_sequence();
        wr_slot  = '0;
        fill_cnt = '0;
        run_sum  = '0;
        best_sum = '0;
    endtask

    // One accepted sample: slide the window, track the best sum, predict on last
    task automatic step_window_sums(
        input logic signed [mwa_pkg::SAMPLE_W-1:0] smp,
        input logic                                lst
    );
        window_result_t    res;
        logic [SLOT_W-1:0] old_slot;
        longint            scaled;
        if (fill_cnt == '0)
            active_len = usable_len(window_reg);
        if (fill_cnt < active_len) begin
            run_sum  = run_sum + smp;
            fill_cnt = fill_cnt + 1'b1;
            if (fill_cnt == active_len)
                best_sum = run_sum;
        end else begin
            // slot of the sample leaving the window, modulo the ring size
            old_slot = wr_slot - active_len[SLOT_W-1:0];
            run_sum  = run_sum + smp - ring[old_slot];
            if (run_sum > best_sum)
                best_sum = run_sum;
        end
        ring[wr_slot] = smp;
        wr_slot       = wr_slot + 1'b1;
        if (lst) begin
            if (fill_cnt < active_len) begin
                res.max_sum   = '0;
                res.average   = '0;
                res.too_short = 1'b1;
            end else begin
                // signed divide truncates toward zero
                scaled        = (longint'(best_sum) <<< mwa_pkg::FRAC_W)
                                / longint'(active_len);
                res.max_sum   = best_sum;
                res.average   = scaled[mwa_pkg::AVG_W-1:0];
                res.too_short = 1'b0;
            end
            expected_results.push_back(res);
            clear_sequence();
        end
    endtask

    // Config, input and output monitors
    always @(posedge aclk) begin
        window_result_t want;
        window_result_t got;
        if (!aresetn) begin
            clear_sequence();
            window_reg = mwa_pkg::WINDOW_LEN_RST;
            active_len = {{(mwa_pkg::LEN_W-1){1'b0}}, 1'b1};
            expected_results.delete();
            in_flight <= 0;
        end else begin
            if (cfg_wr_en)
                window_reg = cfg_wr_data;
            if (s_tvalid && s_tready)
                step_window_sums(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.max_sum   = m_tdata[mwa_pkg::SUM_OUT_W-1:0];
                got.average   = m_tdata[mwa_pkg::SUM_OUT_W +: mwa_pkg::AVG_W];
                got.too_short = m_tuser;
                seen_cnt++;
                if (expected_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result: max_sum %0d average %0d too_short %0b",
                             $time, got.max_sum, got.average, got.too_short);
                end else begin
                    want = expected_results.pop_front();
                    if (got.max_sum !== want.max_sum) begin
                        err_cnt++;
                        $display("%0t: max_sum expected %0d actual %0d",
                                 $time, want.max_sum, got.max_sum);
                    end
                    if (got.average !== want.average) begin
                        err_cnt++;
                        $display("%0t: average expected %0d actual %0d",
                                 $time, want.average, got.average);
                    end
                    if (got.too_short !== want.too_short) begin
                        err_cnt++;
                        $display("%0t: too_short expected %0b actual %0b",
                                 $time, want.too_short, got.too_short);
                    end
                end
            end
            in_flight <= expected_results.size();
        end
    end

endmodule

### test/tb_max_window_average_core.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the max window average block; checking lives in the checker module.
module tb_max_window_average_core;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;     // worst last-sample latency plus slack
    localparam int ITEM_TARGET = 1000;
    localparam int IDLE_PCT    = 31;
    localparam int WINDOW_MAX  = 64;

    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic                              cfg_wr_en   = 1'b0;
    logic [mwa_pkg::LEN_W-1:0]         cfg_wr_data = '0;
    logic                              s_tvalid    = 1'b0;
    logic [mwa_pkg::TDATA_IN_W-1:0]    s_tdata     = '0;
    logic                              s_tlast     = 1'b0;
    logic                              m_tready    = 1'b0;
    logic                              s_tready;
    logic                              m_tvalid;
    logic [mwa_pkg::TDATA_OUT_W-1:0]   m_tdata;
    logic                              m_tuser;

    int errors;
    int outstanding;
    int checked;

    logic calm      = 1'b0;   // no idling on either side while set
    int cycle_cnt   = 0;
    int samples_sent = 0;
    int seqs_sent   = 0;
    int settings_used = 0;

    max_window_average_core #(
        .WINDOW_MAX (WINDOW_MAX)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    mwa_window_checker #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (errors),
        .in_flight    (outstanding),
        .results_seen (checked)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("max_window_average_core: mismatch");
            $finish;
        end
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic int eff_len(input logic [mwa_pkg::LEN_W-1:0] wl);
        if (wl == '0)
            return 1;
        if (wl > WINDOW_MAX)
            return WINDOW_MAX;
        return int'(wl);
    endfunction

    function automatic logic [mwa_pkg::LEN_W-1:0] to_len(input int v);
        return v[mwa_pkg::LEN_W-1:0];
    endfunction

    // Extremes, small values and full-range values
    function automatic logic [mwa_pkg::SAMPLE_W-1:0] pick_sample();
        int unsigned u;
        case ($urandom_range(9))
            0: u = 32'h7fff;
            1: u = 32'h8000;
            2: u = $urandom_range(16) - 8;
            default: u = $urandom;
        endcase
        return u[mwa_pkg::SAMPLE_W-1:0];
    endfunction

    // One request on the sample channel, with random idle cycles ahead of it
    task automatic send_sample(input logic [mwa_pkg::SAMPLE_W-1:0] smp, input logic lst);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        samples_sent++;
        if (lst)
            seqs_sent++;
    endtask

    task automatic send_const(input logic [mwa_pkg::SAMPLE_W-1:0] smp, input int n);
        for (int i = 0; i < n; i++)
            send_sample(smp, i == n - 1);
    endtask

    // Random sequence: mostly full windows, some too short, some exactly one window
    task automatic random_sequence(input int len);
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 12 && len > 1)
            n = $urandom_range(len - 1, 1);
        else if (r < 22)
            n = len;
        else
            n = len + $urandom_range(len + 6, 1);
        for (int i = 0; i < n; i++)
            send_sample(pick_sample(), i == n - 1);
    endtask

    // Let all results drain and the block settle, then write window_len
    task automatic set_window(input logic [mwa_pkg::LEN_W-1:0] wl);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= wl;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [mwa_pkg::LEN_W-1:0] wl;
        int                        r;
        int                        phase;
        int                        n_seq;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, at the reset length of 4
        send_const(16'sh7fff, 4);
        send_const(16'sh8000, 5);
        send_sample(-16'sd7, 1'b1);                  // single sample, too short
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd9, 1'b0);
        send_sample(16'sd11, 1'b1);                  // one short of a window
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd9, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd1, 1'b1);

        // Above-range length clamps to the full ring: largest and smallest sums
        set_window(7'd127);
        send_const(16'sh7fff, WINDOW_MAX);
        send_const(16'sh8000, WINDOW_MAX + 1);
        random_sequence(WINDOW_MAX);

        // Zero length acts as one
        set_window(7'd0);
        send_const(16'sh8000, 1);
        send_const(16'sh7fff, 3);
        random_sequence(1);

        set_window(7'd1);
        random_sequence(1);
        random_sequence(1);
        set_window(7'd65);
        random_sequence(WINDOW_MAX);
        set_window(7'd64);
        random_sequence(WINDOW_MAX);
        set_window(7'd3);
        send_const(-16'sd1, 4);                      // negative average, divides exactly
        random_sequence(3);

        // Random phases, mostly short windows, until the item target is reached
        phase = 0;
        while (samples_sent < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (r < 55)
                wl = to_len($urandom_range(8, 1));
            else if (r < 85)
                wl = to_len($urandom_range(24, 9));
            else if (r < 93)
                wl = to_len($urandom_range(127, 25));
            else
                wl = '0;
            set_window(wl);
            calm <= (phase >= 1 && phase < 3);
            n_seq = $urandom_range(8, 3);
            for (int k = 0; k < n_seq && samples_sent < ITEM_TARGET; k++)
                random_sequence(eff_len(wl));
            phase++;
        end

        // Drain and verdict
        s_tvalid <= 1'b0;
        calm     <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Covered %0d samples in %0d sequences over %0d window settings,",
                 samples_sent, seqs_sent, settings_used + 1);
        $display("including zero, one, full and above-range lengths; %0d results checked.",
                 checked);
        if (errors == 0) begin
            $display("max_window_average_core: match");
        end else begin
            $display("max_window_average_core: mismatch");
        end
        $finish;
    end

endmodule
